// ----- rtl/core/hrp_pkg.sv -----
// Shared constants, phase codes and digit decoding for the hex range parser.
package hrp_pkg;

    localparam int unsigned BOUND_W = 64;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned PHASE_W = 4;

    typedef logic [BOUND_W-1:0] t_bound;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [PHASE_W-1:0] t_phase;

    // Decoded hex digit: valid flag and nibble value
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    // Parse phases
    localparam t_phase PH_L_START = 4'd0;
    localparam t_phase PH_L_ZERO  = 4'd1;
    localparam t_phase PH_L_X     = 4'd2;
    localparam t_phase PH_L_DIG   = 4'd3;
    localparam t_phase PH_H_START = 4'd4;
    localparam t_phase PH_H_ZERO  = 4'd5;
    localparam t_phase PH_H_X     = 4'd6;
    localparam t_phase PH_H_DIG   = 4'd7;
    localparam t_phase PH_DONE    = 4'd8;
    localparam t_phase PH_FAIL    = 4'd9;

    // Characters of interest
    localparam t_char CHAR_NUL   = 8'h00;
    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_DASH  = 8'h2D;
    localparam t_char CHAR_LOW_X = 8'h78;
    localparam t_char CHAR_UP_X  = 8'h58;
    localparam t_char CHAR_LOW_A = 8'h61;
    localparam t_char CHAR_UP_A  = 8'h41;

    function automatic t_digit hex_decode(input t_char c);
        t_digit d;
        t_char  diff;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            diff    = c - CHAR_ZERO;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (c inside {[8'h61:8'h66]}) begin
            diff    = c - CHAR_LOW_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (c inside {[8'h41:8'h46]}) begin
            diff    = c - CHAR_UP_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/hex_range_parser.sv -----
// Streaming parser for "LOW-HIGH" hex ranges, one character word per cycle.
// Usage: send one byte per input word; a zero byte ends the string and yields
// one result word (range_ok, low_bound, high_bound) in the cycle after it is
// accepted, after which the parser is back in its start state. Nonzero bytes
// yield nothing. The phase register and the two 64-bit accumulators update in
// the accept cycle (a 4-bit shift plus digit insert), and the result lands in
// an output register. Input is taken every cycle unless a held result is
// stalled by the consumer; bounds read 0 when the parse fails. No setup time
// after reset.
module hex_range_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hrp_pkg::t_char       i_char_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_range_ok,
    output hrp_pkg::t_bound      o_low_bound,
    output hrp_pkg::t_bound      o_high_bound
);
    import hrp_pkg::*;

    t_phase r_phase, n_phase;
    t_bound r_low, n_low;
    t_bound r_high, n_high;
    logic   r_out_valid;
    logic   r_ok;
    t_bound r_out_low, r_out_high;

    t_digit w_dig;
    logic   w_is_x;
    logic   w_accept;
    logic   w_end;
    logic   w_ok;
    t_bound w_low_shift, w_high_shift, w_dig_ext;

    // Handshake: the output register frees up when drained or being taken
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_end      = (i_char_in == CHAR_NUL);

    // Character decode
    assign w_dig        = hex_decode(i_char_in);
    assign w_is_x       = (i_char_in == CHAR_LOW_X) || (i_char_in == CHAR_UP_X);
    assign w_dig_ext    = {{(BOUND_W-4){1'b0}}, w_dig.value};
    assign w_low_shift  = {r_low[BOUND_W-5:0], w_dig.value};
    assign w_high_shift = {r_high[BOUND_W-5:0], w_dig.value};

    assign w_ok = (r_phase == PH_H_ZERO) || (r_phase == PH_H_X) ||
                  (r_phase == PH_H_DIG) || (r_phase == PH_DONE);

    // Next-state logic of the parser
    always_comb begin
        n_phase = r_phase;
        n_low   = r_low;
        n_high  = r_high;
        if (w_end) begin
            n_phase = PH_L_START;
            n_low   = '0;
            n_high  = '0;
        end else begin
            case (r_phase)
                PH_L_START: begin
                    if (w_dig.valid) begin
                        n_low   = w_dig_ext;
                        n_phase = (i_char_in == CHAR_ZERO) ? PH_L_ZERO : PH_L_DIG;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_L_ZERO: begin
                    if (w_is_x) begin
                        n_phase = PH_L_X;
                    end else if (w_dig.valid) begin
                        n_low   = w_low_shift;
                        n_phase = PH_L_DIG;
                    end else if (i_char_in == CHAR_DASH) begin
                        n_phase = PH_H_START;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_L_X: begin
                    if (w_dig.valid) begin
                        n_low   = w_dig_ext;
                        n_phase = PH_L_DIG;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_L_DIG: begin
                    if (w_dig.valid) begin
                        n_low = w_low_shift;
                    end else if (i_char_in == CHAR_DASH) begin
                        n_phase = PH_H_START;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_H_START: begin
                    if (w_dig.valid) begin
                        n_high  = w_dig_ext;
                        n_phase = (i_char_in == CHAR_ZERO) ? PH_H_ZERO : PH_H_DIG;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_H_ZERO: begin
                    if (w_is_x) begin
                        n_phase = PH_H_X;
                    end else if (w_dig.valid) begin
                        n_high  = w_high_shift;
                        n_phase = PH_H_DIG;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_H_X: begin
                    if (w_dig.valid) begin
                        n_high  = w_dig_ext;
                        n_phase = PH_H_DIG;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_H_DIG: begin
                    if (w_dig.valid) begin
                        n_high = w_high_shift;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_L_START;
            r_low   <= '0;
            r_high  <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_end) begin
            r_ok       <= w_ok;
            r_out_low  <= w_ok ? r_low  : '0;
            r_out_high <= w_ok ? r_high : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_range_ok   = r_ok;
    assign o_low_bound  = r_out_low;
    assign o_high_bound = r_out_high;

endmodule

// ----- rtl/core/hrp_checker.sv -----
// Port-level checker for the hex range parser, bound to the top level.
module hrp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input hrp_pkg::t_char       i_char_in,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_range_ok,
    input hrp_pkg::t_bound      o_low_bound,
    input hrp_pkg::t_bound      o_high_bound
);
    import hrp_pkg::*;

    // A terminating word always produces a result on the next cycle
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_char_in == CHAR_NUL) |=> o_out_valid)
        else $error("terminating word gave no result");

    // A new result only follows an accepted terminating word
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && i_char_in == CHAR_NUL))
        else $error("result without terminating word");

    // Failed parses report zero bounds
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_ok) |-> (o_low_bound == '0 && o_high_bound == '0))
        else $error("failed parse with nonzero bounds");

    // A stalled result stays valid and keeps its low bound
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_low_bound)))
        else $error("stalled result dropped or changed");

endmodule

bind hex_range_parser hrp_checker u_hrp_checker (.*);
